>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the tour permutation mutator.
// Modules that use them must have signals named clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define TPM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen on a rising edge outside reset.
`define TPM_ASSERT_NEVER(label, expr, msg) \
  `TPM_ASSERT(label, !(expr), msg)

`endif

>>> hw/rtl/tpm_pkg.sv
// Shared types and constants of the tour permutation mutator.
// No dependencies; imported by every module of the block.
package tpm_pkg;

  localparam int CITY_W     = 8;
  localparam int MAX_CITIES = 1 << CITY_W;
  localparam int CNT_W      = CITY_W + 1;
  localparam int OP_W       = 3;
  localparam int MIN_CITIES = 4;

  typedef logic [CITY_W-1:0] city_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [OP_W-1:0]   op_t;

  localparam op_t OP_READ       = 3'd0;
  localparam op_t OP_SWAP       = 3'd1;
  localparam op_t OP_SHIFT      = 3'd2;
  localparam op_t OP_SWAP_GROUP = 3'd3;
  localparam op_t OP_INVERT     = 3'd4;
  localparam op_t OP_IDENTITY   = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_TAKE,
    ST_LOAD,
    ST_TURN,
    ST_STORE,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  // Tour memory port: one read or one write a cycle, plus bulk reset to identity.
  typedef struct packed {
    logic  rd_en;
    city_t rd_addr;
    logic  wr_en;
    city_t wr_addr;
    city_t wr_data;
    logic  clear;
  } tour_req_t;

  typedef struct packed {
    logic  rd_en;
    city_t rd_addr;
    logic  wr_en;
    city_t wr_addr;
    city_t wr_data;
  } scr_req_t;

endpackage

>>> hw/rtl/tour_permutation_mutator_core.sv
// Top level of the tour permutation mutator: config register, output register,
// sequencer and the two memories. Uses tpm_pkg, tpm_ctrl, tpm_tour_mem, tpm_scratch_ram.
//
//   channel | direction | handshake        | payload
//   in      | input     | in_valid/stall   | operation, position, group_size, shift_amount
//   out     | output    | out_valid/stall  | city, error
//   cfg     | input     | cfg_wr_en        | cfg_wr_data (city_count)
//
// A read passes through the fetch and take states; reset to identity and
// rejected requests go straight to the result state. A window of L entries
// (2 for swap, g+s, 2g or g) is copied out to scratch and back: each entry
// goes through the single tour memory port once on the way out and once back.
// Reset clears per-entry valid bits, so the identity order is there at once;
// in_stall stays high while rst_n is low.
// A stalled result waits in the output register while the next beat is taken.
module tour_permutation_mutator_core import tpm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  op_t              in_operation,
  input  city_t            in_position,
  input  city_t            in_group_size,
  input  city_t            in_shift_amount,
  output logic             out_valid,
  input  logic             out_stall,
  output city_t            out_city,
  output logic             out_error,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data
);

  cnt_t      city_count_r;
  cnt_t      n_eff;
  logic      accept, busy, take_ok;
  tour_req_t tour_req;
  scr_req_t  scr_req;
  city_t     tour_rd_data, scr_rd_data;
  logic      res_valid, res_err;
  city_t     res_city;
  logic      out_valid_r;
  city_t     out_city_r;
  logic      out_error_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      city_count_r <= cnt_t'(MAX_CITIES);
    end else if (cfg_wr_en) begin
      city_count_r <= cfg_wr_data;
    end
  end

  // Clamp the count into the supported range
  always_comb begin
    if (city_count_r < cnt_t'(MIN_CITIES)) begin
      n_eff = cnt_t'(MIN_CITIES);
    end else if (city_count_r > cnt_t'(MAX_CITIES)) begin
      n_eff = cnt_t'(MAX_CITIES);
    end else begin
      n_eff = city_count_r;
    end
  end

  assign in_stall = busy || !rst_n;
  assign accept   = in_valid && !in_stall;
  assign take_ok  = !out_valid_r || !out_stall;

  tpm_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .n_eff        (n_eff),
    .accept       (accept),
    .op           (in_operation),
    .pos          (in_position),
    .grp          (in_group_size),
    .shamt        (in_shift_amount),
    .take_ok      (take_ok),
    .tour_rd_data (tour_rd_data),
    .scr_rd_data  (scr_rd_data),
    .busy         (busy),
    .tour_req     (tour_req),
    .scr_req      (scr_req),
    .res_valid    (res_valid),
    .res_city     (res_city),
    .res_err      (res_err)
  );

  tpm_tour_mem u_tour_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (tour_req),
    .rd_data (tour_rd_data)
  );

  tpm_scratch_ram u_scratch (
    .clk     (clk),
    .req     (scr_req),
    .rd_data (scr_rd_data)
  );

  // Output register: load a new beat, drop the old one once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_city_r  <= res_city;
      out_error_r <= res_err;
    end
  end

  assign out_valid = out_valid_r;
  assign out_city  = out_city_r;
  assign out_error = out_error_r;

endmodule

>>> hw/rtl/tpm_tour_mem.sv
// Tour memory: one synchronous array with registered read data.
// Per-entry valid bits make an unwritten entry read as its own index. Uses tpm_pkg.
module tpm_tour_mem import tpm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  tour_req_t req,
  output city_t     rd_data
);

  city_t                 mem [MAX_CITIES];
  logic [MAX_CITIES-1:0] valid_r;
  city_t                 rd_raw_r;
  city_t                 rd_addr_r;
  logic                  rd_hit_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_raw_r  <= mem[req.rd_addr];
      rd_addr_r <= req.rd_addr;
      rd_hit_r  <= valid_r[req.rd_addr];
    end
  end

  // Clearing the valid bits restores the identity order at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.clear) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_hit_r ? rd_raw_r : rd_addr_r;

endmodule

>>> hw/rtl/tpm_scratch_ram.sv
// Scratch memory that holds a copy of the mutated window.
// Synchronous array, registered read data, no reset. Uses tpm_pkg.
module tpm_scratch_ram import tpm_pkg::*; (
  input  logic     clk,
  input  scr_req_t req,
  output city_t    rd_data
);

  city_t mem [MAX_CITIES];
  city_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/tpm_ctrl.sv
// Sequencer of the mutator: decodes a request, checks it, and runs the
// copy-out and rotate-back passes over the two memories. Uses tpm_pkg, assert_macros.svh.
`include "assert_macros.svh"
module tpm_ctrl import tpm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cnt_t      n_eff,
  input  logic      accept,
  input  op_t       op,
  input  city_t     pos,
  input  city_t     grp,
  input  city_t     shamt,
  input  logic      take_ok,
  input  city_t     tour_rd_data,
  input  city_t     scr_rd_data,
  output logic      busy,
  output tour_req_t tour_req,
  output scr_req_t  scr_req,
  output logic      res_valid,
  output city_t     res_city,
  output logic      res_err
);

  state_t state_r, state_nxt;
  city_t  pos_r, base_r, k_r, len_r, src_r;
  logic   inv_r;
  logic   ld_pend_r;
  city_t  ld_idx_r;
  logic   st_pend_r;
  city_t  st_pos_r;
  city_t  res_city_r;
  logic   res_err_r;

  cnt_t   p9, g9, nm1, sum9;
  logic   pos_ok, err_dec, grp_op;
  city_t  len_dec, src_dec, nm1_c, pos_inc, src_inc;
  logic   last;

  // Request decode and legality
  always_comb begin
    p9      = {1'b0, pos};
    g9      = {1'b0, grp};
    nm1     = n_eff - cnt_t'(1);
    nm1_c   = nm1[CITY_W-1:0];
    sum9    = g9 + {1'b0, shamt};
    pos_ok  = (p9 != '0) && (p9 < n_eff);
    err_dec = 1'b1;
    grp_op  = 1'b0;
    len_dec = '0;
    src_dec = '0;
    case (op)
      OP_READ: begin
        err_dec = !(p9 < n_eff);
      end
      OP_SWAP: begin
        err_dec = !pos_ok;
        grp_op  = 1'b1;
        len_dec = city_t'(2);
        src_dec = city_t'(1);
      end
      OP_SHIFT: begin
        err_dec = !(pos_ok && (sum9 < nm1));
        grp_op  = 1'b1;
        len_dec = sum9[CITY_W-1:0];
        src_dec = (grp == sum9[CITY_W-1:0]) ? '0 : grp;
      end
      OP_SWAP_GROUP: begin
        err_dec = !(pos_ok && (g9 < (n_eff >> 1)));
        grp_op  = 1'b1;
        len_dec = {grp[CITY_W-2:0], 1'b0};
        src_dec = grp;
      end
      OP_INVERT: begin
        err_dec = !(pos_ok && (g9 < nm1));
        grp_op  = 1'b1;
        len_dec = grp;
        src_dec = grp - city_t'(1);
      end
      OP_IDENTITY: begin
        err_dec = 1'b0;
      end
      default: begin
        err_dec = 1'b1;
      end
    endcase
  end

  assign last    = (k_r == len_r - city_t'(1));
  assign pos_inc = (pos_r == nm1_c) ? city_t'(1) : pos_r + city_t'(1);
  assign src_inc = (src_r + city_t'(1) == len_r) ? '0 : src_r + city_t'(1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (err_dec) begin
            state_nxt = ST_RESULT;
          end else if (op == OP_READ) begin
            state_nxt = ST_FETCH;
          end else if (grp_op && (len_dec != '0)) begin
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_RESULT;
          end
        end
      end
      ST_FETCH: state_nxt = ST_TAKE;
      ST_TAKE:  state_nxt = ST_RESULT;
      ST_LOAD: begin
        if (last) begin
          state_nxt = ST_TURN;
        end
      end
      ST_TURN:  state_nxt = ST_STORE;
      ST_STORE: begin
        if (last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_RESULT;
      ST_RESULT: begin
        if (take_ok) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Memory requests and result strobe
  always_comb begin
    busy             = (state_r != ST_IDLE);
    tour_req.rd_en   = (state_r == ST_FETCH) || (state_r == ST_LOAD);
    tour_req.rd_addr = pos_r;
    tour_req.wr_en   = st_pend_r;
    tour_req.wr_addr = st_pos_r;
    tour_req.wr_data = scr_rd_data;
    tour_req.clear   = accept && (op == OP_IDENTITY);
    scr_req.rd_en    = (state_r == ST_STORE);
    scr_req.rd_addr  = src_r;
    scr_req.wr_en    = ld_pend_r;
    scr_req.wr_addr  = ld_idx_r;
    scr_req.wr_data  = tour_rd_data;
    res_valid        = (state_r == ST_RESULT) && take_ok;
    res_city         = res_city_r;
    res_err          = res_err_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ld_pend_r <= 1'b0;
      st_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ld_pend_r <= (state_r == ST_LOAD);
      st_pend_r <= (state_r == ST_STORE);
    end
  end

  always_ff @(posedge clk) begin
    ld_idx_r <= k_r;
    st_pos_r <= pos_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          pos_r      <= pos;
          base_r     <= pos;
          k_r        <= '0;
          len_r      <= len_dec;
          src_r      <= src_dec;
          inv_r      <= (op == OP_INVERT);
          res_city_r <= '0;
          res_err_r  <= err_dec;
        end
      end
      ST_TAKE: begin
        res_city_r <= tour_rd_data;
      end
      ST_LOAD: begin
        k_r   <= k_r + city_t'(1);
        pos_r <= pos_inc;
      end
      ST_TURN: begin
        // rewind to the window start for the write-back pass
        k_r   <= '0;
        pos_r <= base_r;
      end
      ST_STORE: begin
        k_r   <= k_r + city_t'(1);
        pos_r <= pos_inc;
        src_r <= inv_r ? src_r - city_t'(1) : src_inc;
      end
      default: begin
      end
    endcase
  end

  `TPM_ASSERT_NEVER(a_tour_port_excl, tour_req.rd_en && tour_req.wr_en, "tour rd/wr overlap")
  `TPM_ASSERT_NEVER(a_scr_port_excl, scr_req.rd_en && scr_req.wr_en, "scratch rd/wr overlap")
  `TPM_ASSERT(a_src_in_window, (state_r == ST_STORE) |-> (src_r < len_r), "src out of window")
  `TPM_ASSERT(a_last_load_lands, (state_r == ST_TURN) |-> ld_pend_r, "last load beat lost")
  `TPM_ASSERT_NEVER(a_result_before_wb, (state_r == ST_RESULT) && st_pend_r, "write-back pending")

endmodule

>>> tb/sv/tb_tour_permutation_mutator_core.sv
// Self-checking testbench for tour_permutation_mutator_core: a tour predictor with a
// result scoreboard, directed and random mutation beats, random idling on both channels.
// Depends on tpm_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_tour_permutation_mutator_core import tpm_pkg::*;;

  localparam op_t OP_BAD_LO = 3'd6;
  localparam op_t OP_BAD_HI = 3'd7;
  localparam int  MAX_REPORTS = 10;
  localparam int  PHASE_ITEMS = 80;

  typedef struct packed {
    city_t city;
    logic  error;
  } tour_result_t;

  class tour_scoreboard;
    city_t          tour [MAX_CITIES];
    cnt_t           city_count;
    tour_result_t   pending_results[$];
    int unsigned    mismatches;

    function void reset_tour();
      for (int k = 0; k < MAX_CITIES; k++) tour[k] = city_t'(k);
    endfunction

    function int unsigned eff_count();
      int unsigned n;
      n = city_count;
      if (n < MIN_CITIES) n = MIN_CITIES;
      if (n > MAX_CITIES) n = MAX_CITIES;
      return n;
    endfunction

    // Positions wrap over 1..n-1 so that position 0 stays put.
    function int unsigned wrap(int unsigned base, int unsigned off, int unsigned n);
      return 1 + ((base - 1 + off) % (n - 1));
    endfunction

    function void apply_request(op_t op, city_t p, city_t g, city_t s);
      int unsigned  n, k, a, b, gi, si;
      city_t        t;
      city_t        spare [MAX_CITIES];
      logic         pos_ok;
      tour_result_t res;
      n      = eff_count();
      gi     = g;
      si     = s;
      pos_ok = (p >= 1) && (p < n);
      res    = '0;
      case (op)
        OP_READ: begin
          if (p < n) res.city = tour[p];
          else res.error = 1'b1;
        end
        OP_SWAP: begin
          if (!pos_ok) res.error = 1'b1;
          else begin
            b = wrap(p, 1, n);
            t = tour[p]; tour[p] = tour[b]; tour[b] = t;
          end
        end
        OP_SHIFT: begin
          if (!pos_ok || gi + si >= n - 1) res.error = 1'b1;
          else begin
            for (k = 0; k < gi + si; k++) spare[k] = tour[wrap(p, k, n)];
            for (k = 0; k < si; k++) tour[wrap(p, k, n)] = spare[gi + k];
            for (k = 0; k < gi; k++) tour[wrap(p, si + k, n)] = spare[k];
          end
        end
        OP_SWAP_GROUP: begin
          if (!pos_ok || gi >= n / 2) res.error = 1'b1;
          else begin
            for (k = 0; k < gi; k++) begin
              a = wrap(p, k, n);
              b = wrap(p, gi + k, n);
              t = tour[a]; tour[a] = tour[b]; tour[b] = t;
            end
          end
        end
        OP_INVERT: begin
          if (!pos_ok || gi >= n - 1) res.error = 1'b1;
          else begin
            for (k = 0; k < gi; k++) spare[k] = tour[wrap(p, k, n)];
            for (k = 0; k < gi; k++) tour[wrap(p, k, n)] = spare[gi - 1 - k];
          end
        end
        OP_IDENTITY: reset_tour();
        default: res.error = 1'b1;
      endcase
      pending_results.insert(pending_results.size(), res);
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
    endfunction

    function void check_result(city_t city, logic error);
      tour_result_t exp_res;
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected beat: city %0d error %0d", city, error));
        return;
      end
      exp_res = pending_results.pop_front();
      if (city !== exp_res.city || error !== exp_res.error)
        note_mismatch($sformatf("expected city %0d error %0d, got city %0d error %0d",
                                exp_res.city, exp_res.error, city, error));
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  op_t   in_operation = OP_READ;
  city_t in_position = '0;
  city_t in_group_size = '0;
  city_t in_shift_amount = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  city_t out_city;
  logic  out_error;
  logic  cfg_wr_en = 1'b0;
  cnt_t  cfg_wr_data = '0;

  bit          idle_on = 1'b1;
  int unsigned stall_left = 0;
  int          count_plan[$] = '{4, 0, 3, 511, 257, 256, 5, 6, 17, 40, 100, 255, 128, 9};

  tour_scoreboard sb = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tour_permutation_mutator_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_position     (in_position),
    .in_group_size   (in_group_size),
    .in_shift_amount (in_shift_amount),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_city        (out_city),
    .out_error       (out_error),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  // Check accepted result beats, then pick the next stall value.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_city, out_error);
    if (!idle_on) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    #35_000_000;
    $display("[tour_permutation_mutator_core] ERROR");
    $finish;
  end

  task automatic send_beat(input op_t op, input city_t p, input city_t g, input city_t s);
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_position     <= p;
    in_group_size   <= g;
    in_shift_amount <= s;
    do @(posedge clk); while (in_stall);
    sb.apply_request(op, p, g, s);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Hold off the sender until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_count(input cnt_t value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.city_count = value;
  endtask

  task automatic send_random(input int unsigned n);
    op_t         op;
    city_t       p, g, s;
    int unsigned r, bound, cap, total;
    r = $urandom_range(0, 99);
    if (r < 25) op = OP_READ;
    else if (r < 40) op = OP_SWAP;
    else if (r < 55) op = OP_SHIFT;
    else if (r < 70) op = OP_SWAP_GROUP;
    else if (r < 85) op = OP_INVERT;
    else if (r < 89) op = OP_IDENTITY;
    else if (r < 92) op = OP_BAD_LO;
    else if (r < 95) op = OP_BAD_HI;
    else op = op_t'($urandom_range(0, 7));
    p = ($urandom_range(0, 9) != 0) ? city_t'($urandom_range(1, n - 1))
                                      : city_t'($urandom_range(0, 255));
    g = city_t'($urandom_range(0, 255));
    s = city_t'($urandom_range(0, 255));
    // Keep most windows legal and short; a few span the whole legal range.
    if ($urandom_range(0, 7) != 0) begin
      case (op)
        OP_SHIFT:      bound = n - 2;
        OP_SWAP_GROUP: bound = n / 2 - 1;
        default:       bound = n - 2;
      endcase
      cap = ($urandom_range(0, 19) == 0 || bound < 12) ? bound : 12;
      if (op == OP_SHIFT) begin
        total = $urandom_range(0, cap);
        g = city_t'($urandom_range(0, total));
        s = city_t'(total - g);
      end else begin
        g = city_t'($urandom_range(0, cap));
      end
    end
    send_beat(op, p, g, s);
  endtask

  initial begin
    int unsigned n;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    sb.reset_tour();
    sb.city_count = MAX_CITIES;
    @(posedge clk);

    // Directed beats at the full city count.
    send_beat(OP_READ, 8'd0, 8'd0, 8'd0);
    send_beat(OP_READ, 8'd255, 8'd255, 8'd255);
    send_beat(OP_SWAP, 8'd1, 8'd0, 8'd0);
    send_beat(OP_SWAP, 8'd255, 8'd0, 8'd0);
    send_beat(OP_SWAP, 8'd0, 8'd0, 8'd0);
    send_beat(OP_SHIFT, 8'd10, 8'd3, 8'd4);
    send_beat(OP_SHIFT, 8'd200, 8'd100, 8'd154);
    send_beat(OP_SHIFT, 8'd20, 8'd200, 8'd55);
    send_beat(OP_SHIFT, 8'd30, 8'd0, 8'd5);
    send_beat(OP_SHIFT, 8'd40, 8'd5, 8'd0);
    send_beat(OP_SHIFT, 8'd0, 8'd1, 8'd1);
    send_beat(OP_SWAP_GROUP, 8'd250, 8'd127, 8'd0);
    send_beat(OP_SWAP_GROUP, 8'd5, 8'd128, 8'd0);
    send_beat(OP_SWAP_GROUP, 8'd5, 8'd0, 8'd0);
    send_beat(OP_INVERT, 8'd100, 8'd254, 8'd0);
    send_beat(OP_INVERT, 8'd100, 8'd255, 8'd0);
    send_beat(OP_INVERT, 8'd7, 8'd0, 8'd0);
    send_beat(OP_INVERT, 8'd0, 8'd3, 8'd0);
    send_beat(OP_BAD_LO, 8'd3, 8'd2, 8'd1);
    send_beat(OP_BAD_HI, 8'd255, 8'd255, 8'd255);
    send_beat(OP_READ, 8'd128, 8'd0, 8'd0);
    send_beat(OP_IDENTITY, 8'd0, 8'd0, 8'd0);
    send_beat(OP_READ, 8'd255, 8'd0, 8'd0);
    send_beat(OP_READ, 8'd1, 8'd0, 8'd0);
    drain();

    // Each phase keeps the tour from the one before, so count changes see a mutated tour.
    foreach (count_plan[i]) begin
      write_count(cnt_t'(count_plan[i]));
      n = sb.eff_count();
      idle_on = (i == count_plan.size() - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      if (n < MAX_CITIES) send_beat(OP_READ, city_t'(n), 8'd0, 8'd0);
      send_beat(OP_READ, city_t'(n - 1), 8'd0, 8'd0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2 && i == 2) drain();
        send_random(n);
      end
      drain();
    end

    repeat (32) @(posedge clk);
    sb.mismatches += sb.pending_results.size();
    if (sb.mismatches == 0) begin
      $display("[tour_permutation_mutator_core] OK");
    end else begin
      $display("[tour_permutation_mutator_core] ERROR");
    end
    $finish;
  end

endmodule
